// ===== sv/lcd4_pkg.sv =====
// shared types, constants and helpers for the 4-bit character lcd sequencer
package lcd4_pkg;

  localparam int LINE_COLUMNS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_POS   = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [2:0] CFG_CURSOR_ON     = 3'd0;
  localparam logic [2:0] CFG_BLINK_ON      = 3'd1;
  localparam logic [2:0] CFG_CHAR_PAUSE_MS = 3'd2;
  localparam logic [2:0] CFG_INSTR_WAIT_US = 3'd3;
  localparam logic [2:0] CFG_DATA_WAIT_US  = 3'd4;

  localparam logic [15:0] INSTR_WAIT_RESET = 16'd1000;
  localparam logic [15:0] DATA_WAIT_RESET  = 16'd40;

  localparam logic [7:0] SET_ADDR_BASE = 8'h80;
  localparam logic [7:0] LINE2_BASE    = 8'h40;
  localparam logic [7:0] CHAR_LT       = 8'h3C;
  localparam logic [7:0] CHAR_GT       = 8'h3E;
  localparam logic [7:0] GLYPH_LT      = 8'h7F;
  localparam logic [7:0] GLYPH_GT      = 8'h7E;
  localparam logic [3:0] NIB_WAKE      = 4'b0011;
  localparam logic [3:0] NIB_4BIT      = 4'b0010;
  localparam logic [7:0] INSTR_FUNC    = 8'h28;
  localparam logic [7:0] INSTR_OFF     = 8'h08;
  localparam logic [7:0] INSTR_CLEAR   = 8'h01;
  localparam logic [7:0] INSTR_ENTRY   = 8'(2'b11 << 1);
  localparam logic [7:0] INSTR_DISP_ON = 8'h0C;
  localparam logic [9:0] MS_TO_US      = 10'd1000;
  localparam logic [4:0] COL_MAX       = 5'd31;

  localparam logic [3:0] INIT_LAST_STEP = 4'd13;
  localparam logic [3:0] INIT_WAKE_STEPS = 4'd4;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_INSTR,
    OP_DATA
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  byte_val;
    logic [25:0] wait_before;
  } job_t;

  typedef struct packed {
    logic        cursor_on;
    logic        blink_on;
    logic [15:0] char_pause_ms;
    logic [15:0] instr_wait_us;
    logic [15:0] data_wait_us;
  } cfg_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic cursor,
                                           input logic blink);
    logic [7:0] b;
    case (idx)
      3'd0:    b = INSTR_FUNC;
      3'd1:    b = INSTR_OFF;
      3'd2:    b = INSTR_CLEAR;
      3'd3:    b = INSTR_ENTRY;
      default: b = INSTR_DISP_ON | {6'd0, cursor, blink};
    endcase
    return b;
  endfunction

endpackage

// ===== sv/lcd4_front.sv =====
// command front end: classifies commands, tracks the cursor column, builds jobs
module lcd4_front import lcd4_pkg::*; #(
  parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_char_code,
  input  logic       in_line,
  input  logic [3:0] in_column_offset,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  localparam logic [5:0] COLS = 6'(LINE_COLUMNS);

  logic [4:0] cursor_column_r, cursor_column_nxt;
  logic       accept;
  logic       emit;
  logic [7:0] glyph;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (in_char_code)
      CHAR_LT: glyph = GLYPH_LT;
      CHAR_GT: glyph = GLYPH_GT;
      default: glyph = in_char_code;
    endcase
  end

  always_comb begin
    emit              = 1'b0;
    cursor_column_nxt = cursor_column_r;
    q_job.op          = OP_INSTR;
    q_job.byte_val    = glyph;
    q_job.wait_before = '0;
    case (in_kind)
      KIND_INIT: begin
        emit              = 1'b1;
        q_job.op          = OP_INIT;
        cursor_column_nxt = '0;
      end
      KIND_POS: begin
        emit              = 1'b1;
        q_job.op          = OP_INSTR;
        q_job.byte_val    = SET_ADDR_BASE + (in_line ? LINE2_BASE : 8'h00)
                            + {4'd0, in_column_offset};
        cursor_column_nxt = {1'b0, in_column_offset};
      end
      KIND_WRITE: begin
        // zero bytes and writes past the line end are dropped
        if (in_char_code != 8'd0 && {1'b0, cursor_column_r} < COLS) begin
          emit              = 1'b1;
          q_job.op          = OP_DATA;
          q_job.wait_before = 26'(cfg.char_pause_ms) * 26'(MS_TO_US);
          if (cursor_column_r < COL_MAX) begin
            cursor_column_nxt = cursor_column_r + 5'd1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_column_r <= '0;
    end else if (accept) begin
      cursor_column_r <= cursor_column_nxt;
    end
  end

endmodule

// ===== sv/lcd4_queue.sv =====
// small job queue between the command front end and the transfer back end
module lcd4_queue import lcd4_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/lcd4_back.sv =====
// transfer back end: expands jobs into nibble transfers into an output register
module lcd4_back import lcd4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  input  cfg_t        cfg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic [25:0] out_wait_before_us,
  output logic [15:0] out_wait_after_us,
  output logic        out_last
);

  logic [3:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        rs_r, last_r;
  logic [3:0]  nib_r;
  logic [25:0] before_r;
  logic [15:0] after_r;

  logic        load;
  logic        final_step;
  logic [3:0]  init_idx;
  logic        lo_half;
  logic [7:0]  cur_byte;
  logic        rs_c;
  logic [3:0]  nib_c;
  logic [25:0] before_c;
  logic [15:0] after_c;

  assign load       = !q_empty && (!out_valid_r || out_ready);
  assign final_step = (q_job.op == OP_INIT) ? (step_r == INIT_LAST_STEP) : step_r[0];
  assign q_pop      = load && final_step;
  assign init_idx   = step_r - INIT_WAKE_STEPS;

  always_comb begin
    rs_c     = (q_job.op == OP_DATA);
    lo_half  = step_r[0];
    cur_byte = q_job.byte_val;
    nib_c    = '0;
    before_c = '0;
    after_c  = '0;
    if (q_job.op == OP_INIT) begin
      lo_half  = init_idx[0];
      cur_byte = init_byte(init_idx[3:1], cfg.cursor_on, cfg.blink_on);
    end
    if (q_job.op == OP_INIT && step_r < INIT_WAKE_STEPS) begin
      // wake-up nibbles, each preceded by an instruction wait
      nib_c    = (step_r == INIT_WAKE_STEPS - 4'd1) ? NIB_4BIT : NIB_WAKE;
      before_c = 26'(cfg.instr_wait_us);
    end else if (!lo_half) begin
      nib_c    = cur_byte[7:4];
      before_c = q_job.wait_before;
    end else begin
      nib_c   = cur_byte[3:0];
      after_c = (q_job.op == OP_DATA) ? cfg.data_wait_us : cfg.instr_wait_us;
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = final_step ? 4'd0 : step_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= rs_c;
      nib_r    <= nib_c;
      before_r <= before_c;
      after_r  <= after_c;
      last_r   <= final_step;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reg_select     = rs_r;
  assign out_nibble         = nib_r;
  assign out_wait_before_us = before_r;
  assign out_wait_after_us  = after_r;
  assign out_last           = last_r;

endmodule

// ===== sv/char_lcd_4bit_sequencer.sv =====
// top level: 4-bit character lcd sequencer with configuration registers
// the first transfer of an item passes through the job queue and then the back end's output register
// throughput: one transfer per cycle from the back end's nibble counter while out_ready holds; init
//   expands into 14 transfers, set position and write character into 2, dropped items none
// reset: config to its reset values, cursor column 0, queue and output register empty
module char_lcd_4bit_sequencer import lcd4_pkg::*; #(
  parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic        in_line,
  input  logic [3:0]  in_column_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic [25:0] out_wait_before_us,
  output logic [15:0] out_wait_after_us,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CURSOR_ON:     cfg_nxt.cursor_on     = cfg_data[0];
        CFG_BLINK_ON:      cfg_nxt.blink_on      = cfg_data[0];
        CFG_CHAR_PAUSE_MS: cfg_nxt.char_pause_ms = cfg_data;
        CFG_INSTR_WAIT_US: cfg_nxt.instr_wait_us = cfg_data;
        CFG_DATA_WAIT_US:  cfg_nxt.data_wait_us  = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cursor_on     <= 1'b0;
      cfg_r.blink_on      <= 1'b0;
      cfg_r.char_pause_ms <= '0;
      cfg_r.instr_wait_us <= INSTR_WAIT_RESET;
      cfg_r.data_wait_us  <= DATA_WAIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcd4_front #(
    .LINE_COLUMNS(LINE_COLUMNS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_char_code    (in_char_code),
    .in_line         (in_line),
    .in_column_offset(in_column_offset),
    .cfg             (cfg_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  lcd4_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  lcd4_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_job             (pop_job),
    .q_pop             (q_pop),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reg_select    (out_reg_select),
    .out_nibble        (out_nibble),
    .out_wait_before_us(out_wait_before_us),
    .out_wait_after_us (out_wait_after_us),
    .out_last          (out_last)
  );

endmodule

// ===== tb/lcd4_checker.sv =====
// checker for the lcd sequencer: predicts nibble transfers per command and compares them
module lcd4_checker #(
  parameter int LINE_COLUMNS = lcd4_pkg::LINE_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic        in_line,
  input  logic [3:0]  in_column_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_reg_select,
  input  logic [3:0]  out_nibble,
  input  logic [25:0] out_wait_before_us,
  input  logic [15:0] out_wait_after_us,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcd4_pkg::*;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;
  localparam int   REPORT_MAX = 10;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [25:0] wait_pre;
    logic [15:0] after;
    logic        last;
  } lcd_xfer_t;

  cfg_t       regs;
  logic [4:0] column;
  lcd_xfer_t  expected_xfers[$];
  int         fail_count = 0;
  int         seen = 0;

  task automatic push_xfer(input logic rs, input logic [3:0] nib, input logic [25:0] wait_pre,
                           input logic [15:0] after, input logic last);
    lcd_xfer_t x;
    x = {rs, nib, wait_pre, after, last};
    expected_xfers.push_back(x);
  endtask

  // high nibble carries the wait before, low nibble the wait after
  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [25:0] wait_pre,
                           input logic [15:0] after, input logic last);
    push_xfer(rs, b[7:4], wait_pre, 16'd0, 1'b0);
    push_xfer(rs, b[3:0], 26'd0, after, last);
  endtask

  task automatic expand_command(input logic [1:0] kind, input logic [7:0] ch,
                                input logic ln, input logic [3:0] off);
    logic [7:0] glyph;
    logic [7:0] line_base;
    case (kind)
      KIND_INIT: begin
        repeat (3) push_xfer(RS_INSTR, NIB_WAKE, 26'(regs.instr_wait_us), 16'd0, 1'b0);
        push_xfer(RS_INSTR, NIB_4BIT, 26'(regs.instr_wait_us), 16'd0, 1'b0);
        push_byte(RS_INSTR, INSTR_FUNC, 26'd0, regs.instr_wait_us, 1'b0);
        push_byte(RS_INSTR, INSTR_OFF, 26'd0, regs.instr_wait_us, 1'b0);
        push_byte(RS_INSTR, INSTR_CLEAR, 26'd0, regs.instr_wait_us, 1'b0);
        push_byte(RS_INSTR, INSTR_ENTRY, 26'd0, regs.instr_wait_us, 1'b0);
        push_byte(RS_INSTR, INSTR_DISP_ON | {6'd0, regs.cursor_on, regs.blink_on}, 26'd0,
                  regs.instr_wait_us, 1'b1);
        // clear homes the cursor
        column = 5'd0;
      end
      KIND_POS: begin
        line_base = ln ? LINE2_BASE : 8'h00;
        push_byte(RS_INSTR, SET_ADDR_BASE + line_base + {4'd0, off}, 26'd0,
                  regs.instr_wait_us, 1'b1);
        column = {1'b0, off};
      end
      KIND_WRITE: begin
        // zero bytes and writes past the line end are dropped
        if (ch != 8'h00 && int'(column) < LINE_COLUMNS) begin
          if (ch == CHAR_LT) glyph = GLYPH_LT;
          else if (ch == CHAR_GT) glyph = GLYPH_GT;
          else glyph = ch;
          push_byte(RS_DATA, glyph, 26'(regs.char_pause_ms) * 26'(MS_TO_US),
                    regs.data_wait_us, 1'b1);
          if (column != COL_MAX) column = column + 5'd1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    lcd_xfer_t got;
    lcd_xfer_t want;
    if (!rst_n) begin
      regs.cursor_on     = 1'b0;
      regs.blink_on      = 1'b0;
      regs.char_pause_ms = 16'd0;
      regs.instr_wait_us = INSTR_WAIT_RESET;
      regs.data_wait_us  = DATA_WAIT_RESET;
      column = 5'd0;
      expected_xfers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CURSOR_ON:     regs.cursor_on = cfg_data[0];
          CFG_BLINK_ON:      regs.blink_on = cfg_data[0];
          CFG_CHAR_PAUSE_MS: regs.char_pause_ms = cfg_data;
          CFG_INSTR_WAIT_US: regs.instr_wait_us = cfg_data;
          CFG_DATA_WAIT_US:  regs.data_wait_us = cfg_data;
          default: ;
        endcase
      end
      // compare before predicting so a new item never pairs with an older transfer
      if (out_valid && out_ready) begin
        got = {out_reg_select, out_nibble, out_wait_before_us, out_wait_after_us, out_last};
        seen++;
        if (expected_xfers.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: transfer %0d with nothing expected: %s%0d nib=%h %s%0d%s%0d%s%0d",
                     $time, seen, "rs=", got.rs, got.nib, "before=", got.wait_pre,
                     " after=", got.after, " last=", got.last);
        end else begin
          want = expected_xfers.pop_front();
          if (got.rs !== want.rs || got.nib !== want.nib || got.wait_pre !== want.wait_pre ||
              got.after !== want.after || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: transfer %0d expected rs=%0d nib=%h before=%0d after=%0d last=%0d",
                       $time, seen, want.rs, want.nib, want.wait_pre, want.after, want.last);
              $display("%0t: transfer %0d actual   rs=%0d nib=%h before=%0d after=%0d last=%0d",
                       $time, seen, got.rs, got.nib, got.wait_pre, got.after, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expand_command(in_kind, in_char_code, in_line, in_column_offset);
    end
    errors  <= fail_count;
    pending <= expected_xfers.size();
    checked <= seen;
  end

endmodule

// ===== tb/tb_char_lcd_4bit_sequencer.sv =====
// top-level testbench: drives commands and register settings into the lcd sequencer
module tb_char_lcd_4bit_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import lcd4_pkg::*;

  localparam int          CYCLE_LIMIT   = 100000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          PHASE_ITEMS   = 80;
  localparam int          RANDOM_PHASES = 4;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [2:0]  CFG_SPARE     = 3'd5;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_char_code;
  logic        in_line;
  logic [3:0]  in_column_offset;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_reg_select;
  logic [3:0]  out_nibble;
  logic [25:0] out_wait_before_us;
  logic [15:0] out_wait_after_us;
  logic        out_last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int   errors;
  int   pending;
  int   checked;
  logic calm = 1'b0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   cmds_sent = 0;
  int   settings_applied = 0;

  char_lcd_4bit_sequencer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_char_code(in_char_code), .in_line(in_line), .in_column_offset(in_column_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_reg_select(out_reg_select),
    .out_nibble(out_nibble), .out_wait_before_us(out_wait_before_us),
    .out_wait_after_us(out_wait_after_us), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lcd4_checker lcd_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_char_code(in_char_code), .in_line(in_line), .in_column_offset(in_column_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_reg_select(out_reg_select),
    .out_nibble(out_nibble), .out_wait_before_us(out_wait_before_us),
    .out_wait_after_us(out_wait_after_us), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_lcd_4bit_sequencer: mismatch");
      $finish;
    end
  end

  // valid stays high between back-to-back items; only a gap lowers it
  task automatic send_cmd(input logic [1:0] kind, input logic [7:0] ch, input logic ln,
                          input logic [3:0] off);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_char_code     <= ch;
    in_line          <= ln;
    in_column_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmds_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic cur, input logic blk, input logic [15:0] pause,
                               input logic [15:0] iwait, input logic [15:0] dwait);
    drain();
    put_reg(CFG_SPARE, 16'($urandom));
    put_reg(CFG_CURSOR_ON, {15'($urandom), cur});
    put_reg(CFG_BLINK_ON, {15'($urandom), blk});
    put_reg(CFG_CHAR_PAUSE_MS, pause);
    put_reg(CFG_INSTR_WAIT_US, iwait);
    put_reg(CFG_DATA_WAIT_US, dwait);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [15:0] pick_wait();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int         r;
    int         useful;
    int         stim_col;
    logic [1:0] kind;
    logic [7:0] ch;
    logic       ln;
    logic [3:0] off;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_INIT;
    in_char_code     <= 8'h00;
    in_line          <= 1'b0;
    in_column_offset <= 4'd0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_CURSOR_ON;
    cfg_data         <= 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset timing first, junk in unused fields
    send_cmd(KIND_INIT, 8'hFF, 1'b1, 4'hF);
    send_cmd(KIND_WRITE, 8'h41, 1'b1, 4'hF);
    send_cmd(KIND_WRITE, CHAR_LT, 1'b0, 4'h0);
    send_cmd(KIND_WRITE, CHAR_GT, 1'b0, 4'h0);
    send_cmd(KIND_WRITE, 8'h00, 1'b1, 4'h5);
    send_cmd(KIND_WRITE, 8'hFF, 1'b0, 4'h0);
    send_cmd(KIND_POS, 8'hFF, 1'b1, 4'hF);
    send_cmd(KIND_WRITE, 8'h01, 1'b0, 4'h0);
    // column now at the line end, so this write is dropped
    send_cmd(KIND_WRITE, 8'h78, 1'b0, 4'h0);
    send_cmd(KIND_UNUSED, 8'hFF, 1'b1, 4'hF);
    send_cmd(KIND_POS, 8'h00, 1'b0, 4'h0);
    send_cmd(KIND_UNUSED, 8'h00, 1'b0, 4'h0);

    apply_setting(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(KIND_INIT, 8'h00, 1'b0, 4'h0);
    send_cmd(KIND_POS, 8'h00, 1'b1, 4'h0);
    send_cmd(KIND_WRITE, 8'h80, 1'b1, 4'hA);
    send_cmd(KIND_WRITE, CHAR_LT, 1'b0, 4'h0);

    apply_setting(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_INIT, 8'h3C, 1'b1, 4'h3);
    send_cmd(KIND_WRITE, 8'h7F, 1'b0, 4'h0);
    send_cmd(KIND_POS, 8'h00, 1'b0, 4'hF);
    send_cmd(KIND_WRITE, 8'h55, 1'b0, 4'h0);
    send_cmd(KIND_WRITE, 8'hAA, 1'b1, 4'hF);
    send_cmd(KIND_POS, 8'h00, 1'b1, 4'hA);
    stim_col = 10;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_setting(1'($urandom), 1'($urandom), pick_wait(), pick_wait(), pick_wait());
      // no idling on either side in the closing phase
      if (phase == RANDOM_PHASES - 1) calm <= 1'b1;
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        r    = $urandom_range(0, 99);
        ch   = 8'($urandom);
        ln   = 1'($urandom);
        off  = 4'($urandom);
        kind = KIND_WRITE;
        if (r < 6) begin
          kind = KIND_INIT;
          stim_col = 0;
          useful++;
        end else if (r < 30) begin
          kind = KIND_POS;
          // lean toward the line end so full-line drops show up
          if ($urandom_range(0, 2) == 0) off = 4'($urandom_range(12, 15));
          stim_col = off;
          useful++;
        end else if (r < 94) begin
          case ($urandom_range(0, 7))
            0:       ch = CHAR_LT;
            1:       ch = CHAR_GT;
            default: if (ch == 8'h00) ch = 8'h20;
          endcase
          if (stim_col < LINE_COLUMNS_DEF) begin
            stim_col++;
            useful++;
          end
        end else if (r < 97) begin
          kind = KIND_UNUSED;
        end else begin
          ch = 8'h00;
        end
        send_cmd(kind, ch, ln, off);
      end
    end

    drain();
    $display("run covered %0d commands over %0d register settings, %0d transfers checked",
             cmds_sent, settings_applied, checked);
    $display("random phases mixed init, position and character items with input gaps and stalls");
    if (errors == 0 && pending == 0)
      $display("char_lcd_4bit_sequencer: match");
    else
      $display("char_lcd_4bit_sequencer: mismatch");
    $finish;
  end

endmodule
